// ===== src/pbw_pkg.sv =====
// ----------------------------------------------------------------------------
// pbw_pkg
// Shared constants for the pixel boundary weight stream.
// ----------------------------------------------------------------------------
package pbw_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int PIX_W     = 24;
	localparam int WT_W      = 17;

	// ln 2 in Q.32
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	// configuration register indexes
	localparam logic REG_IMAGE_WIDTH = 1'b0;
	localparam logic REG_INV_SIGMA   = 1'b1;

	typedef logic [PIX_W-1:0] pixel_t;

endpackage

// ===== src/pbw_ram.sv =====
// ----------------------------------------------------------------------------
// pbw_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pbw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== src/pbw_weight.sv =====
// ----------------------------------------------------------------------------
// pbw_weight
// Iterative boundary weight unit: integer square root of the RGB distance,
// scale by 1/(2 sigma^2), range reduction by ln 2 and a ten-term series
// for exp(-r), then rounding to Q1.16.
// ----------------------------------------------------------------------------
module pbw_weight import pbw_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  pixel_t          pix_a,
	input  pixel_t          pix_b,
	input  logic [31:0]     inv_sigma,
	output logic            done,
	output logic [WT_W-1:0] weight
);

	typedef enum logic [2:0] {
		W_IDLE, W_SQRT, W_MUL, W_DIVK, W_EMUL, W_EDIV, W_FIN
	} wstate_t;

	wstate_t state_q;

	logic [33:0] v_q;
	logic [34:0] res_q;
	logic [33:0] bit_q;
	logic [37:0] x_q;
	logic [2:0]  kbit_q;
	logic [5:0]  k_q;
	logic [32:0] t_q;
	logic [3:0]  n_q;
	logic [39:0] m_q;
	logic [3:0]  rem_q;
	logic [2:0]  dcnt_q;
	logic [31:0] inv_q;

	// channel distance squared
	logic [8:0]  dr, dg, db;
	logic [17:0] d2;
	always_comb begin
		dr = {1'b0, pix_a[23:16]} - {1'b0, pix_b[23:16]};
		dg = {1'b0, pix_a[15:8]} - {1'b0, pix_b[15:8]};
		db = {1'b0, pix_a[7:0]} - {1'b0, pix_b[7:0]};
		if (dr[8]) dr = -dr;
		if (dg[8]) dg = -dg;
		if (db[8]) db = -db;
		d2 = 18'(dr[7:0] * dr[7:0]) + 18'(dg[7:0] * dg[7:0]) + 18'(db[7:0] * db[7:0]);
	end

	// one square root step
	logic [34:0] trial;
	always_comb trial = res_q + {1'b0, bit_q};

	// scaled distance and clamp
	logic [48:0] prod_x;
	logic [40:0] x_raw;
	logic [37:0] x_clamped;
	always_comb begin
		prod_x    = 49'(res_q[16:0]) * 49'(inv_q);
		x_raw     = prod_x[48:8];
		x_clamped = (x_raw > 41'(38'd32 << 32)) ? (38'd32 << 32) : x_raw[37:0];
	end

	logic [37:0] ln2_sh;
	always_comb ln2_sh = 38'(LN2_Q32) << kbit_q;

	// series product
	logic [64:0] prod_e;
	always_comb prod_e = 65'(x_q[31:0]) * 65'(t_q);

	// eight quotient bits per cycle by a small divisor
	logic [3:0] rem_n;
	logic [7:0] qbits;
	logic [4:0] part;
	always_comb begin
		rem_n = rem_q;
		qbits = '0;
		for (int i = 0; i < 8; i++) begin
			part = {rem_n, m_q[39-i]};
			if (part >= {1'b0, n_q}) begin
				part     = part - {1'b0, n_q};
				qbits[7-i] = 1'b1;
			end
			rem_n = part[3:0];
		end
	end

	// final rounding
	logic [55:0] rsum;
	logic [55:0] rshift;
	always_comb begin
		rsum   = 56'(t_q) + (56'd1 << (6'd15 + k_q));
		rshift = rsum >> (6'd16 + k_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				W_IDLE: begin
					if (start) begin
						v_q     <= {d2, 16'd0};
						res_q   <= '0;
						bit_q   <= 34'd1 << 32;
						inv_q   <= inv_sigma;
						state_q <= W_SQRT;
					end
				end
				W_SQRT: begin
					if (v_q >= trial[33:0]) begin
						v_q   <= v_q - trial[33:0];
						res_q <= (res_q >> 1) + {1'b0, bit_q};
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q == 34'd1) state_q <= W_MUL;
				end
				W_MUL: begin
					x_q     <= x_clamped;
					k_q     <= '0;
					kbit_q  <= 3'd5;
					state_q <= W_DIVK;
				end
				W_DIVK: begin
					if (x_q >= ln2_sh) begin
						x_q          <= x_q - ln2_sh;
						k_q[kbit_q] <= 1'b1;
					end
					kbit_q <= kbit_q - 3'd1;
					if (kbit_q == 3'd0) begin
						t_q     <= 33'd1 << 32;
						n_q     <= 4'd10;
						state_q <= W_EMUL;
					end
				end
				W_EMUL: begin
					m_q     <= {7'd0, prod_e[64:32]};
					rem_q   <= '0;
					dcnt_q  <= '0;
					state_q <= W_EDIV;
				end
				W_EDIV: begin
					m_q    <= {m_q[31:0], qbits};
					rem_q  <= rem_n;
					dcnt_q <= dcnt_q + 3'd1;
					if (dcnt_q == 3'd4) begin
						t_q <= (33'd1 << 32) - {m_q[24:0], qbits};
						n_q <= n_q - 4'd1;
						state_q <= (n_q == 4'd1) ? W_FIN : W_EMUL;
					end
				end
				W_FIN: begin
					weight  <= (k_q >= 6'd40) ? '0 : rshift[WT_W-1:0];
					done    <= 1'b1;
					state_q <= W_IDLE;
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

endmodule

// ===== src/pixel_boundary_weight_stream.sv =====
// ----------------------------------------------------------------------------
// pixel_boundary_weight_stream
// Graph-cut boundary weights for left and upper neighbors of a raster
// RGB pixel stream, using a line buffer in RAM and an iterative exp unit.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       in_valid / in_ready       red, green, blue, first_of_frame
//  out      out_valid / out_ready     edge_direction, edge_weight,
//                                     column_index, last_of_run
//  cfg      cfg_we                    cfg_index, cfg_data
//
// One pixel at a time. Each weight runs through the iterative weight unit
// (start, 17 square root steps, scale, 6 range steps, 10 series terms,
// round), then done is seen and the result is pushed. A pixel is held up
// further while out_ready is low.
// The line buffer is read once and written back once per pixel.
// Reset clears position state; the line buffer is not cleared.
// A held output blocks only the next result push, not the input capture.
module pixel_boundary_weight_stream import pbw_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      red,
	input  logic [7:0]      green,
	input  logic [7:0]      blue,
	input  logic            first_of_frame,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            edge_direction,
	output logic [WT_W-1:0] edge_weight,
	output logic [11:0]     column_index,
	output logic            last_of_run,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [31:0]     cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_LEFT, S_LPUSH, S_UP, S_UPUSH, S_DONE
	} state_t;

	state_t state_q;

	logic [12:0]      width_q;
	logic [31:0]      inv_q;
	logic [COL_W-1:0] col_cnt_q;
	logic             pfr_q;
	pixel_t           prev_q;
	pixel_t           pix_q;
	pixel_t           above_q;
	pixel_t           b_q;
	logic [COL_W-1:0] col_q;
	logic             pfr_s_q;
	logic             start_q;
	logic [WT_W-1:0]  wt_q;

	logic             wu_done;
	logic [WT_W-1:0]  wu_weight;
	logic             acc;
	logic             push_ok;
	logic             push_now;
	logic [COL_W-1:0] col_now;
	logic [COL_W-1:0] ram_addr;
	pixel_t           ram_rdata;
	logic [13:0]      width_eff;
	logic [13:0]      col_next;

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;
	assign push_ok  = !out_valid || out_ready;
	assign push_now = push_ok && (state_q inside {S_LPUSH, S_UPUSH});
	assign col_now  = first_of_frame ? '0 : col_cnt_q;
	assign ram_addr = (state_q == S_IDLE) ? col_now : col_q;

	always_comb begin
		if (width_q == 13'd0) width_eff = 14'd1;
		else if (14'(width_q) > 14'(MAX_WIDTH)) width_eff = 14'(MAX_WIDTH);
		else width_eff = 14'(width_q);
		col_next = 14'(col_q) + 14'd1;
	end

	pbw_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
		.clk   (clk),
		.we    (state_q == S_DONE),
		.addr  (ram_addr),
		.wdata (pix_q),
		.rdata (ram_rdata)
	);

	pbw_weight u_weight (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.pix_a     (pix_q),
		.pix_b     (b_q),
		.inv_sigma (inv_q),
		.done      (wu_done),
		.weight    (wu_weight)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 13'd640;
			inv_q   <= 32'd2386093;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= cfg_data[12:0];
				REG_INV_SIGMA:   inv_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			col_cnt_q <= '0;
			pfr_q     <= 1'b0;
			prev_q    <= '0;
			start_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid && out_ready && !push_now) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						pix_q   <= {red, green, blue};
						col_q   <= col_now;
						pfr_s_q <= first_of_frame ? 1'b0 : pfr_q;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					above_q <= ram_rdata;
					if (col_q != '0) begin
						b_q     <= prev_q;
						start_q <= 1'b1;
						state_q <= S_LEFT;
					end else if (pfr_s_q) begin
						b_q     <= ram_rdata;
						start_q <= 1'b1;
						state_q <= S_UP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_LEFT: begin
					if (wu_done) begin
						wt_q    <= wu_weight;
						state_q <= S_LPUSH;
					end
				end
				S_LPUSH: begin
					if (push_ok) begin
						out_valid      <= 1'b1;
						edge_direction <= 1'b0;
						edge_weight    <= wt_q;
						column_index   <= 12'(col_q);
						last_of_run    <= !pfr_s_q;
						if (pfr_s_q) begin
							b_q     <= above_q;
							start_q <= 1'b1;
							state_q <= S_UP;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_UP: begin
					if (wu_done) begin
						wt_q    <= wu_weight;
						state_q <= S_UPUSH;
					end
				end
				S_UPUSH: begin
					if (push_ok) begin
						out_valid      <= 1'b1;
						edge_direction <= 1'b1;
						edge_weight    <= wt_q;
						column_index   <= 12'(col_q);
						last_of_run    <= 1'b1;
						state_q        <= S_DONE;
					end
				end
				S_DONE: begin
					// line buffer write happens this cycle
					prev_q <= pix_q;
					if (col_next >= width_eff) begin
						col_cnt_q <= '0;
						pfr_q     <= 1'b1;
					end else begin
						col_cnt_q <= col_next[COL_W-1:0];
						pfr_q     <= pfr_s_q;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== dv/pixel_boundary_weight_stream_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_boundary_weight_stream_tb
// Streams RGB frames through the boundary weight block under random
// handshake pressure and checks every left and upper edge weight against
// a bit-exact predictor of the square root and exp arithmetic.
// ----------------------------------------------------------------------------
module pixel_boundary_weight_stream_tb;
	import pbw_pkg::*;

	typedef struct {
		logic            dir;
		logic [WT_W-1:0] weight;
		logic [11:0]     col;
		logic            last;
	} edge_result_t;

	localparam logic [63:0] ONE_Q32  = 64'd1 << 32;
	localparam logic [63:0] LN2_WIDE = 64'd2977044472;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_ready;
	logic [7:0]      red = '0, green = '0, blue = '0;
	logic            first_of_frame = 1'b0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	logic            edge_direction;
	logic [WT_W-1:0] edge_weight;
	logic [11:0]     column_index;
	logic            last_of_run;
	logic            cfg_we = 1'b0;
	logic            cfg_index = 1'b0;
	logic [31:0]     cfg_data = '0;

	// predictor state
	pixel_t       line_mem [MAX_WIDTH];
	bit           line_written [MAX_WIDTH];
	pixel_t       prev_pix;
	int unsigned  col_count;
	bit           below_first_row;
	logic [12:0]  width_reg;
	logic [31:0]  inv_sigma_reg;

	edge_result_t pending_edges[$];
	int           errors = 0;
	int           pixels_sent = 0;
	int           edges_seen = 0;
	bit           calm = 1'b0;

	pixel_boundary_weight_stream DUT (.*);

	always #5 clk = ~clk;

	function automatic logic [WT_W-1:0] boundary_weight(pixel_t a, pixel_t b,
			logic [31:0] inv);
		logic [63:0] d2, v, res, bitv, x, k, r, t;
		int          dr, dg, db;
		dr = int'(a[23:16]) - int'(b[23:16]);
		dg = int'(a[15:8]) - int'(b[15:8]);
		db = int'(a[7:0]) - int'(b[7:0]);
		d2 = 64'(dr * dr + dg * dg + db * db);
		v = d2 << 16;
		res = '0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		x = (res * 64'(inv)) >> 8;
		if (x > (64'd32 << 32))
			x = 64'd32 << 32;
		k = x / LN2_WIDE;
		r = x - k * LN2_WIDE;
		t = ONE_Q32;
		for (int n = 10; n >= 1; n--)
			t = ONE_Q32 - ((r * t) >> 32) / 64'(n);
		if (k >= 40)
			return '0;
		return WT_W'((t + (64'd1 << (15 + k))) >> (16 + k));
	endfunction

	// advance the predictor by one accepted pixel
	task automatic predict_pixel(pixel_t pix, logic ff);
		int unsigned  w, col;
		edge_result_t e;
		int           n0;
		w = (width_reg < 1) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
		if (ff) begin
			col_count = 0;
			below_first_row = 1'b0;
		end
		col = (col_count >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_count;
		n0 = pending_edges.size();
		if (col > 0) begin
			e = '{1'b0, boundary_weight(pix, prev_pix, inv_sigma_reg), 12'(col), 1'b0};
			pending_edges.push_back(e);
		end
		if (below_first_row) begin
			e = '{1'b1, boundary_weight(pix, line_mem[col], inv_sigma_reg), 12'(col), 1'b0};
			pending_edges.push_back(e);
		end
		if (pending_edges.size() > n0)
			pending_edges[$].last = 1'b1;
		line_mem[col] = pix;
		line_written[col] = 1'b1;
		prev_pix = pix;
		if (col + 1 >= w) begin
			col_count = 0;
			below_first_row = 1'b1;
		end else begin
			col_count = col + 1;
		end
	endtask

	// entered and left at a falling edge
	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic ff);
		int unsigned col;
		col = (col_count >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_count;
		// never read a line buffer column that holds nothing yet
		if (!ff && below_first_row && !line_written[col])
			ff = 1'b1;
		if (!calm)
			while ($urandom_range(99) < 26) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		in_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		first_of_frame <= ff;
		do
			@(posedge clk);
		while (!in_ready);
		predict_pixel({r, g, b}, ff);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic send_random(logic ff);
		send_pixel(8'($urandom), 8'($urandom), 8'($urandom), ff);
	endtask

	// drain, then let a result-free pixel finish before touching registers
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_edges.size() != 0)
			@(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			width_reg = data[12:0];
		else
			inv_sigma_reg = data;
		@(negedge clk);
	endtask

	always @(negedge clk)
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);

	always @(posedge clk) begin
		edge_result_t e;
		if (arst_n && out_valid && out_ready) begin
			edges_seen++;
			if (pending_edges.size() == 0) begin
				$error("unexpected edge result: dir %0d weight %0d col %0d",
					edge_direction, edge_weight, column_index);
				errors++;
			end else begin
				e = pending_edges.pop_front();
				if (edge_direction !== e.dir) begin
					$error("edge_direction expected %0d actual %0d", e.dir, edge_direction);
					errors++;
				end
				if (edge_weight !== e.weight) begin
					$error("edge_weight expected %0d actual %0d", e.weight, edge_weight);
					errors++;
				end
				if (column_index !== e.col) begin
					$error("column_index expected %0d actual %0d", e.col, column_index);
					errors++;
				end
				if (last_of_run !== e.last) begin
					$error("last_of_run expected %0d actual %0d", e.last, last_of_run);
					errors++;
				end
			end
		end
	end

	task automatic test_reset_defaults();
		// default width 640: first row, left edges only
		send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
		send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
		settle();
	endtask

	task automatic test_small_frame();
		write_reg(REG_IMAGE_WIDTH, 32'd2);
		send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
		send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
		send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
		send_pixel(8'h80, 8'h7F, 8'h01, 1'b0);
		settle();
	endtask

	task automatic test_sigma_extremes();
		logic [31:0] sig [3] = '{32'd0, 32'd1, 32'hFFFF_FFFF};
		write_reg(REG_IMAGE_WIDTH, 32'd3);
		foreach (sig[i]) begin
			write_reg(REG_INV_SIGMA, sig[i]);
			send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
			send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
			send_pixel(8'h01, 8'h00, 8'h00, 1'b0);
			send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
			settle();
		end
		write_reg(REG_INV_SIGMA, 32'd2386093);
	endtask

	task automatic test_width_clamp();
		// zero acts as one: every pixel is its own row
		write_reg(REG_IMAGE_WIDTH, 32'd0);
		send_pixel(8'h10, 8'h20, 8'h30, 1'b1);
		send_pixel(8'hF0, 8'hE0, 8'hD0, 1'b0);
		send_pixel(8'hF0, 8'hE0, 8'hD1, 1'b0);
		settle();
		write_reg(REG_IMAGE_WIDTH, 32'h1FFF);
		send_random(1'b1);
		repeat (3) send_random(1'b0);
		settle();
		write_reg(REG_IMAGE_WIDTH, 32'd4096);
		send_random(1'b1);
		repeat (3) send_random(1'b0);
		settle();
	endtask

	task automatic test_shrink_mid_row();
		write_reg(REG_IMAGE_WIDTH, 32'd8);
		send_random(1'b1);
		repeat (4) send_random(1'b0);
		settle();
		// column 5 is beyond the new width: the row ends after this pixel
		write_reg(REG_IMAGE_WIDTH, 32'd3);
		repeat (5) send_random(1'b0);
		settle();
	endtask

	task automatic test_random_frames();
		int budget, w, len;
		bit first_frame;
		budget = 360;
		while (budget > 0) begin
			first_frame = (budget == 360);
			settle();
			case ($urandom_range(9))
				0: write_reg(REG_IMAGE_WIDTH, 32'($urandom_range(16, 64)));
				1: write_reg(REG_IMAGE_WIDTH, 32'($urandom_range(1, 2)));
				default: write_reg(REG_IMAGE_WIDTH, 32'($urandom_range(2, 8)));
			endcase
			case ($urandom_range(3))
				0: write_reg(REG_INV_SIGMA, $urandom);
				1: write_reg(REG_INV_SIGMA, 32'($urandom_range(0, 32'h00FF_FFFF)));
				default: write_reg(REG_INV_SIGMA, 32'd2386093);
			endcase
			// the first frame is a long stretch with no idling on either side
			calm = first_frame || ($urandom_range(4) == 0);
			w = (width_reg < 1) ? 1 : width_reg;
			len = w * $urandom_range(2, 5) + $urandom_range(0, 3);
			if (len > 60 || first_frame)
				len = 60;
			for (int i = 0; i < len && budget > 0; i++) begin
				if (i == 0)
					send_random(1'b1);
				else if ($urandom_range(29) == 0)
					send_random(1'b1);
				else if ($urandom_range(3) == 0)
					// near neighbor of the last pixel for mid-range weights
					send_pixel(prev_pix[23:16] ^ 8'($urandom_range(7)),
						prev_pix[15:8] ^ 8'($urandom_range(7)),
						prev_pix[7:0] ^ 8'($urandom_range(7)), 1'b0);
				else
					send_random(1'b0);
				budget--;
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		width_reg = 13'd640;
		inv_sigma_reg = 32'd2386093;
		prev_pix = '0;
		col_count = 0;
		below_first_row = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_small_frame();
		test_sigma_extremes();
		test_width_clamp();
		test_shrink_mid_row();
		test_random_frames();
		settle();
		$display("Covered %0d pixels and %0d edge weights over clamped, small and",
			pixels_sent, edges_seen);
		$display("random widths with zero, default, random and full-scale sigma.");
		if (errors == 0)
			$display("pixel_boundary_weight_stream_tb: PASS");
		else
			$display("pixel_boundary_weight_stream_tb: FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("pixel_boundary_weight_stream_tb: FAIL");
		$finish;
	end

endmodule
